### design/eia_pkg.sv
package eia_pkg;

  localparam int unsigned ID_CAPACITY_DEF    = 1024;
  localparam int unsigned SIGNATURE_BITS_DEF = 32;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned SIG_IO_W = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LIVE_W   = 11;

  localparam logic [63:0] ERR_SIGNATURE = 64'd4056;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_SET     = 2'd2,
    ACT_GET     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_RANGE      = 2'd2,
    STAT_NONE_LIVING = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } eia_cmd_t;

  typedef struct packed {
    logic clear_last;
  } eia_sts_t;

endpackage

### design/eia_ctrl.sv
module eia_ctrl
  import eia_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  eia_sts_t sts,
  output eia_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold the read data until the output register can take the word
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

### design/eia_datapath.sv
module eia_datapath
  import eia_pkg::*;
#(
  parameter int unsigned ID_CAPACITY    = ID_CAPACITY_DEF,
  parameter int unsigned SIGNATURE_BITS = SIGNATURE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  eia_cmd_t            cmd,
  output eia_sts_t            sts,
  input  logic [1:0]          action,
  input  logic [ID_W-1:0]     entity_id,
  input  logic [SIG_IO_W-1:0] signature_in,
  output logic [ID_W-1:0]     new_id,
  output logic [SIG_IO_W-1:0] signature_out,
  output logic [STAT_W-1:0]   status,
  output logic [LIVE_W-1:0]   living_count
);

  localparam int unsigned IDX_W = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(ID_CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(ID_CAPACITY);
  localparam logic [SIGNATURE_BITS-1:0] ERR_SIG = ERR_SIGNATURE[SIGNATURE_BITS-1:0];

  logic [IDX_W-1:0]          fifo_mem [ID_CAPACITY];
  logic [SIGNATURE_BITS-1:0] sig_mem  [ID_CAPACITY];

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             tail_wrapped, tail_wrapped_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] clr_addr;

  action_t                   act_q;
  logic                      in_range_q;
  logic [IDX_W-1:0]          idx_q;
  logic [SIGNATURE_BITS-1:0] sig_q;
  logic [IDX_W-1:0]          fifo_rd;
  logic [SIGNATURE_BITS-1:0] sig_rd;

  logic [31:0]               in_id_wide;
  logic [63:0]               in_sig_wide;
  logic [IDX_W-1:0]          in_idx;

  logic                      fifo_we;
  logic                      sig_we;
  logic [IDX_W-1:0]          sig_waddr;
  logic [SIGNATURE_BITS-1:0] sig_wdata;
  logic [IDX_W-1:0]          pop_id;
  logic [31:0]               pop_wide;
  status_t                   status_c;
  logic [ID_W-1:0]           new_id_c;
  logic [SIGNATURE_BITS-1:0] sig_out_c;
  logic [63:0]               sig_out_wide;
  logic [31:0]               count_wide;

  assign in_id_wide  = 32'(entity_id);
  assign in_sig_wide = 64'(signature_in);
  assign in_idx      = in_id_wide[IDX_W-1:0];

  assign sts.clear_last = (clr_addr == LAST_IDX);

  // entries past the fill mark have never been written, so the index itself is used
  assign pop_id   = (tail_wrapped || (head < tail)) ? fifo_rd : head;
  assign pop_wide = 32'(pop_id);

  always_comb begin
    head_next         = head;
    tail_next         = tail;
    tail_wrapped_next = tail_wrapped;
    count_next        = count;
    fifo_we           = 1'b0;
    sig_we            = 1'b0;
    sig_waddr         = idx_q;
    sig_wdata         = '0;
    status_c          = STAT_OK;
    new_id_c          = '0;
    sig_out_c         = '0;
    case (act_q)
      ACT_CREATE: begin
        if (count == CAP_CNT) begin
          status_c = STAT_NO_FREE;
        end else begin
          new_id_c   = pop_wide[ID_W-1:0];
          head_next  = (head == LAST_IDX) ? '0 : head + 1'b1;
          count_next = count + 1'b1;
        end
      end
      ACT_DESTROY: begin
        if (!in_range_q) begin
          status_c = STAT_RANGE;
        end else if (count == '0) begin
          status_c = STAT_NONE_LIVING;
        end else begin
          sig_we  = cmd.commit;
          fifo_we = cmd.commit;
          if (tail == LAST_IDX) begin
            tail_next         = '0;
            tail_wrapped_next = 1'b1;
          end else begin
            tail_next = tail + 1'b1;
          end
          count_next = count - 1'b1;
        end
      end
      ACT_SET: begin
        if (!in_range_q) begin
          status_c = STAT_RANGE;
        end else begin
          sig_we    = cmd.commit;
          sig_wdata = sig_q;
        end
      end
      ACT_GET: begin
        if (!in_range_q) begin
          status_c  = STAT_RANGE;
          sig_out_c = ERR_SIG;
        end else begin
          sig_out_c = sig_rd;
        end
      end
      default: status_c = STAT_OK;
    endcase
    // sweep the signature table to zero after reset
    if (cmd.clear) begin
      sig_we    = 1'b1;
      sig_waddr = clr_addr;
      sig_wdata = '0;
    end
  end

  assign sig_out_wide = 64'(sig_out_c);
  assign count_wide   = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      tail_wrapped <= 1'b0;
      count        <= '0;
      clr_addr     <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        head         <= head_next;
        tail         <= tail_next;
        tail_wrapped <= tail_wrapped_next;
        count        <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q      <= action_t'(action);
      in_range_q <= (in_id_wide < 32'(ID_CAPACITY));
      idx_q      <= in_idx;
      sig_q      <= in_sig_wide[SIGNATURE_BITS-1:0];
      fifo_rd    <= fifo_mem[head];
      sig_rd     <= sig_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[tail] <= idx_q;
    if (sig_we) sig_mem[sig_waddr] <= sig_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      new_id        <= new_id_c;
      signature_out <= sig_out_wide[SIG_IO_W-1:0];
      status        <= status_c;
      living_count  <= count_wide[LIVE_W-1:0];
    end
  end

endmodule

### design/entity_id_allocator.sv
// A result word is presented from the output register after its input word is accepted
// in ST_IDLE and its update is committed in ST_EXEC; a new word is accepted only after the
// previous one has committed. The free list and the signature table are read into registers
// when a word is loaded. A waiting result word stalls the update cycle of the next word.
// Reset (rst, synchronous): the signature table is swept to zero, one entry per
// cycle, through all ID_CAPACITY entries; s_tready stays low until the sweep ends.
module entity_id_allocator
  import eia_pkg::*;
#(
  parameter int unsigned ID_CAPACITY    = ID_CAPACITY_DEF,
  parameter int unsigned SIGNATURE_BITS = SIGNATURE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // action[1:0], entity_id[11:2], signature_in[43:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // new_id[9:0], signature_out[41:10], status[43:42],
                                 // living_count[54:44]
);

  eia_cmd_t            cmd;
  eia_sts_t            sts;
  logic [ID_W-1:0]     new_id;
  logic [SIG_IO_W-1:0] signature_out;
  logic [STAT_W-1:0]   status;
  logic [LIVE_W-1:0]   living_count;

  eia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eia_datapath #(
    .ID_CAPACITY    (ID_CAPACITY),
    .SIGNATURE_BITS (SIGNATURE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (s_tdata[1:0]),
    .entity_id     (s_tdata[11:2]),
    .signature_in  (s_tdata[43:12]),
    .new_id        (new_id),
    .signature_out (signature_out),
    .status        (status),
    .living_count  (living_count)
  );

  assign m_tdata = {1'b0, living_count, status, signature_out, new_id};

endmodule
